/* rtl/core/bus_region_decode_waitstates_defines.svh */
// ---------------------------------------------------------------------------
// Bus region decoder assertion macros
// Shared assertion forms for the bus region decoder checkers.
// ---------------------------------------------------------------------------
`ifndef BUS_REGION_DECODE_WAITSTATES_DEFINES_SVH
`define BUS_REGION_DECODE_WAITSTATES_DEFINES_SVH

// Check on every rising edge, skip while reset is held.
`define BRDW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on every rising edge, reset included.
`define BRDW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/brdw_pkg.sv */
// ---------------------------------------------------------------------------
// Bus region decoder package
// Region codes, page ranges, register indexes and wait-state tables.
// ---------------------------------------------------------------------------
package brdw_pkg;

    typedef logic [3:0]  t_region;
    typedef logic [27:0] t_offset;
    typedef logic [4:0]  t_wait;
    typedef logic [7:0]  t_page;

    localparam t_region REGION_BIOS    = 4'd0;
    localparam t_region REGION_EWRAM   = 4'd1;
    localparam t_region REGION_IWRAM   = 4'd2;
    localparam t_region REGION_IO      = 4'd3;
    localparam t_region REGION_PALETTE = 4'd4;
    localparam t_region REGION_VRAM    = 4'd5;
    localparam t_region REGION_OAM     = 4'd6;
    localparam t_region REGION_ROM     = 4'd7;
    localparam t_region REGION_SRAM    = 4'd8;
    localparam t_region REGION_EEPROM  = 4'd9;
    localparam t_region REGION_UNUSED  = 4'd10;

    // Access width codes; code three behaves as a word.
    localparam logic [1:0] WIDTH_BYTE = 2'd0;
    localparam logic [1:0] WIDTH_HALF = 2'd1;
    localparam logic [1:0] WIDTH_WORD = 2'd2;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WAIT_CONTROL = 2'd0;
    localparam logic [1:0] CFG_ROM_MIRROR   = 2'd1;
    localparam logic [1:0] CFG_BACKUP_KIND  = 2'd2;
    localparam logic [1:0] CFG_RTC_PRESENT  = 2'd3;

    localparam int CFG_DATA_W = 25;

    localparam logic [14:0] WAIT_CONTROL_RESET = 15'h0000;
    localparam logic [24:0] ROM_MIRROR_RESET   = 25'h1FF_FFFF;

    localparam logic [1:0] BACKUP_NONE   = 2'd0;
    localparam logic [1:0] BACKUP_SRAM   = 2'd1;

    // Page ranges of the top address byte.
    localparam t_page PAGE_INT_FIRST  = 8'h00;
    localparam t_page PAGE_INT_LAST   = 8'h07;
    localparam t_page PAGE_ROM_FIRST  = 8'h08;
    localparam t_page PAGE_ROM_LAST   = 8'h0D;
    localparam t_page PAGE_EEPROM     = 8'h0D;
    localparam t_page PAGE_SRAM_FIRST = 8'h0E;
    localparam t_page PAGE_SRAM_LAST  = 8'h0F;

    localparam logic [15:0] EEPROM_WINDOW_MID = 16'hFFFF;
    localparam logic [7:0]  RTC_FIRST         = 8'hC4;
    localparam logic [7:0]  RTC_LAST          = 8'hC9;
    localparam logic [27:0] SRAM_OFFSET_MASK  = 28'hEFF_FFFF;

    // Nonsequential wait table, indexed by a two-bit N field.
    function automatic logic [3:0] nonseq_wait(input logic [1:0] nf);
        logic [3:0] w;
        unique case (nf)
            2'd0:    w = 4'd4;
            2'd1:    w = 4'd3;
            2'd2:    w = 4'd2;
            default: w = 4'd8;
        endcase
        return w;
    endfunction

    // Sequential wait table, indexed by waitstate number and S field.
    function automatic logic [3:0] seq_wait(input logic [1:0] ws, input logic sf);
        logic [3:0] w;
        if (sf) begin
            w = 4'd1;
        end else begin
            unique case (ws)
                2'd0:    w = 4'd2;
                2'd1:    w = 4'd4;
                default: w = 4'd8;
            endcase
        end
        return w;
    endfunction

    // Assumed internal page waits: 8/16-bit or 32-bit.
    function automatic t_wait internal_wait(input logic [2:0] page, input logic word);
        t_wait w;
        unique case (page) inside
            3'd2:       w = word ? 5'd6 : 5'd3;
            3'd5, 3'd6: w = word ? 5'd2 : 5'd1;
            default:    w = 5'd1;
        endcase
        return w;
    endfunction

    function automatic t_region page_region(input logic [2:0] page);
        t_region r;
        unique case (page)
            3'd0:    r = REGION_BIOS;
            3'd1:    r = REGION_UNUSED;
            3'd2:    r = REGION_EWRAM;
            3'd3:    r = REGION_IWRAM;
            3'd4:    r = REGION_IO;
            3'd5:    r = REGION_PALETTE;
            3'd6:    r = REGION_VRAM;
            default: r = REGION_OAM;
        endcase
        return r;
    endfunction

    typedef struct packed {
        t_region region;
        t_offset local_offset;
        t_wait   wait_cycles;
        logic    rtc_window;
        logic    write_dropped;
        logic    fill_ones;
    } t_result;

endpackage

/* rtl/core/brdw_access_if.sv */
// ---------------------------------------------------------------------------
// Bus access channel
// Valid/ready channel carrying one bus access per beat.
// ---------------------------------------------------------------------------
interface brdw_access_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] address;
    logic [1:0]  access_width;
    logic        sequential;

    modport source (output valid, output cmd, output address, output access_width,
                    output sequential, input ready);
    modport sink   (input valid, input cmd, input address, input access_width,
                    input sequential, output ready);
endinterface

/* rtl/core/brdw_result_if.sv */
// ---------------------------------------------------------------------------
// Decode result channel
// Valid/ready channel carrying one decoded access per beat.
// ---------------------------------------------------------------------------
interface brdw_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  region;
    logic [27:0] local_offset;
    logic [4:0]  wait_cycles;
    logic        rtc_window;
    logic        write_dropped;
    logic        fill_ones;

    modport source (output valid, output region, output local_offset, output wait_cycles,
                    output rtc_window, output write_dropped, output fill_ones,
                    input ready);
    modport sink   (input valid, input region, input local_offset, input wait_cycles,
                    input rtc_window, input write_dropped, input fill_ones,
                    output ready);
endinterface

/* rtl/core/bus_region_decode_waitstates.sv */
// ---------------------------------------------------------------------------
// Bus region decoder with wait states
// Decodes one bus access into region, local offset, cycle cost and flags.
// ---------------------------------------------------------------------------
// Usage:
//   i_acc carries one access per beat (cmd, address, access_width,
//   sequential); o_res returns exactly one decoded beat per access, in order.
//   Both are valid/ready channels; a beat moves when valid and ready are high.
//   The configuration port writes register i_cfg_index from i_cfg_data when
//   i_cfg_we is high; write it only while no access is in flight.
//   An access lands in the input register, is decoded in one pass of short
//   logic, and lands in the result register, where it is shown on o_res.
//   Throughput is one access per cycle while o_res is not stalled, set by the
//   two-stage register pipeline; nothing in the decode iterates.
//   When the receiver stalls, the result register holds its beat and the
//   input register holds one more; i_acc.ready drops only when both are full.
//   Synchronous reset empties both stages and loads the configuration reset
//   values (wait control 0, ROM mirror mask all ones, no backup, no clock).
// ---------------------------------------------------------------------------
module bus_region_decode_waitstates (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    brdw_access_if.sink                       i_acc,
    brdw_result_if.source                     o_res,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [brdw_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import brdw_pkg::*;

    // Configuration registers.
    logic [14:0] r_wait_control;
    logic [24:0] r_rom_mirror;
    logic [1:0]  r_backup_kind;
    logic        r_rtc_present;

    // Input stage.
    logic        r_s1_valid;
    logic        r_s1_cmd;
    logic [31:0] r_s1_address;
    logic [1:0]  r_s1_width;
    logic        r_s1_seq;

    // Result stage.
    logic        r_s2_valid;
    t_result     r_s2_res;
    t_result     n_s2_res;

    logic        w_s1_adv;
    logic        w_in_take;

    // Advance the input stage whenever the result register is free or drains.
    assign w_s1_adv    = !r_s2_valid || o_res.ready;
    assign i_acc.ready = !r_s1_valid || w_s1_adv;
    assign w_in_take   = i_acc.valid && i_acc.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_control <= WAIT_CONTROL_RESET;
            r_rom_mirror   <= ROM_MIRROR_RESET;
            r_backup_kind  <= BACKUP_NONE;
            r_rtc_present  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WAIT_CONTROL: r_wait_control <= i_cfg_data[14:0];
                CFG_ROM_MIRROR:   r_rom_mirror   <= i_cfg_data[24:0];
                CFG_BACKUP_KIND:  r_backup_kind  <= i_cfg_data[1:0];
                CFG_RTC_PRESENT:  r_rtc_present  <= i_cfg_data[0];
                default:          r_rtc_present  <= r_rtc_present;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_acc.ready) begin
                r_s1_valid <= i_acc.valid;
            end
            if (w_s1_adv) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers: load without reset.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_cmd     <= i_acc.cmd;
            r_s1_address <= i_acc.address;
            r_s1_width   <= i_acc.access_width;
            r_s1_seq     <= i_acc.sequential;
        end
        if (w_s1_adv && r_s1_valid) begin
            r_s2_res <= n_s2_res;
        end
    end

    // -----------------------------------------------------------------------
    // Decode
    // -----------------------------------------------------------------------
    logic        w_wr;
    logic        w_word;
    logic        w_half;
    t_page       w_page;
    logic [27:0] w_al;
    logic [1:0]  w_ws;
    logic [1:0]  w_nf;
    logic        w_sf;
    logic [3:0]  w_n;
    logic [3:0]  w_s;
    t_wait       w_rom_wait;
    logic [24:0] w_rom_off;
    logic        w_rtc;
    logic        w_eeprom;
    logic [16:0] w_vram;

    assign w_wr   = (r_s1_cmd == CMD_WRITE);
    assign w_word = r_s1_width[1];
    assign w_half = (r_s1_width == WIDTH_HALF);
    assign w_page = r_s1_address[31:24];

    // Align: words drop bits 1:0, halfwords bit 0, bytes keep all.
    assign w_al = {r_s1_address[27:2],
                   w_word ? 1'b0 : r_s1_address[1],
                   (w_word || w_half) ? 1'b0 : r_s1_address[0]};

    // Waitstate select: pages 8/9 use WS0, A/B WS1, C/D WS2.
    assign w_ws = r_s1_address[26:25];
    always_comb begin
        unique case (w_ws)
            2'd0: begin
                w_nf = r_wait_control[3:2];
                w_sf = r_wait_control[4];
            end
            2'd1: begin
                w_nf = r_wait_control[6:5];
                w_sf = r_wait_control[7];
            end
            default: begin
                w_nf = r_wait_control[9:8];
                w_sf = r_wait_control[10];
            end
        endcase
    end
    assign w_n = nonseq_wait(w_nf);
    assign w_s = seq_wait(w_ws, w_sf);

    // 8/16-bit: one access; 32-bit: N+S, or two S when sequential.
    always_comb begin
        if (!w_word) begin
            w_rom_wait = 5'd1 + (r_s1_seq ? {1'b0, w_s} : {1'b0, w_n});
        end else if (r_s1_seq) begin
            w_rom_wait = {w_s + 4'd1, 1'b0};
        end else begin
            w_rom_wait = 5'd2 + {1'b0, w_n} + {1'b0, w_s};
        end
    end

    assign w_rom_off = w_al[24:0] & r_rom_mirror;
    assign w_rtc     = (w_rom_off[24:8] == '0) &&
                       (w_rom_off[7:0] >= RTC_FIRST) && (w_rom_off[7:0] <= RTC_LAST);
    assign w_eeprom  = (w_page == PAGE_EEPROM) && w_half && r_backup_kind[1] &&
                       (r_s1_address[23:8] == EEPROM_WINDOW_MID);

    // VRAM: 128K window, upper 32K mirrors the 32K below it.
    assign w_vram = {w_al[16], w_al[15] & ~w_al[16], w_al[14:0]};

    always_comb begin
        n_s2_res               = '0;
        n_s2_res.region        = REGION_UNUSED;
        n_s2_res.wait_cycles   = 5'd1;
        unique case (w_page) inside
            [PAGE_INT_FIRST:PAGE_INT_LAST]: begin
                n_s2_res.region      = page_region(w_page[2:0]);
                n_s2_res.wait_cycles = internal_wait(w_page[2:0], w_word);
                case (n_s2_res.region) inside
                    REGION_EWRAM:                 n_s2_res.local_offset = {10'd0, w_al[17:0]};
                    REGION_IWRAM:                 n_s2_res.local_offset = {13'd0, w_al[14:0]};
                    REGION_PALETTE, REGION_OAM:   n_s2_res.local_offset = {18'd0, w_al[9:0]};
                    REGION_VRAM:                  n_s2_res.local_offset = {11'd0, w_vram};
                    REGION_UNUSED:                n_s2_res.local_offset = '0;
                    default:                      n_s2_res.local_offset = w_al;
                endcase
                n_s2_res.write_dropped = w_wr && ((n_s2_res.region == REGION_BIOS) ||
                                                  (n_s2_res.region == REGION_UNUSED));
            end
            [PAGE_ROM_FIRST:PAGE_ROM_LAST]: begin
                n_s2_res.wait_cycles = w_rom_wait;
                if (w_eeprom) begin
                    n_s2_res.region       = REGION_EEPROM;
                    n_s2_res.local_offset = w_al;
                end else begin
                    // Pass ROM writes only into the clock window, never bytes.
                    n_s2_res.region        = REGION_ROM;
                    n_s2_res.local_offset  = {3'd0, w_rom_off};
                    n_s2_res.rtc_window    = w_rtc;
                    n_s2_res.write_dropped = w_wr && !(w_rtc && r_rtc_present &&
                                                       (r_s1_width != WIDTH_BYTE));
                end
            end
            [PAGE_SRAM_FIRST:PAGE_SRAM_LAST]: begin
                n_s2_res.region        = REGION_SRAM;
                n_s2_res.local_offset  = r_s1_address[27:0] & SRAM_OFFSET_MASK;
                n_s2_res.wait_cycles   = 5'd1 + {1'b0, nonseq_wait(r_wait_control[1:0])};
                // No SRAM fitted: drop writes, read back all ones.
                n_s2_res.write_dropped = w_wr && (r_backup_kind != BACKUP_SRAM);
                n_s2_res.fill_ones     = !w_wr && (r_backup_kind != BACKUP_SRAM);
            end
            default: begin
                n_s2_res.write_dropped = w_wr;
            end
        endcase
    end

    assign o_res.valid         = r_s2_valid;
    assign o_res.region        = r_s2_res.region;
    assign o_res.local_offset  = r_s2_res.local_offset;
    assign o_res.wait_cycles   = r_s2_res.wait_cycles;
    assign o_res.rtc_window    = r_s2_res.rtc_window;
    assign o_res.write_dropped = r_s2_res.write_dropped;
    assign o_res.fill_ones     = r_s2_res.fill_ones;

endmodule

/* rtl/core/brdw_checker.sv */
// ---------------------------------------------------------------------------
// Bus region decoder checker
// Port-level checks on the result channel, bound to the decoder.
// ---------------------------------------------------------------------------
`include "bus_region_decode_waitstates_defines.svh"

module brdw_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [3:0]  i_region,
    input  logic [27:0] i_local_offset,
    input  logic [4:0]  i_wait_cycles,
    input  logic        i_rtc_window,
    input  logic        i_write_dropped,
    input  logic        i_fill_ones
);
    import brdw_pkg::*;

    // Reset empties the pipeline.
    `BRDW_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !i_res_valid, "result valid after reset")

    // A stalled beat holds.
    `BRDW_ASSERT(a_stall_holds, i_clk, i_rst_n, i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_region) && $stable(i_local_offset) && $stable(i_wait_cycles), "stalled result beat changed")

    // Unused pages give a zero offset, the default wait value and no all-ones fill.
    `BRDW_ASSERT(a_unused_shape, i_clk, i_rst_n, i_res_valid && i_region == REGION_UNUSED |-> i_local_offset == '0 && i_wait_cycles == 5'd1 && !i_fill_ones, "unused region beat malformed")

    // Flags only appear with the regions that own them.
    `BRDW_ASSERT(a_flag_regions, i_clk, i_rst_n, i_res_valid |-> (!i_rtc_window || i_region == REGION_ROM) && (!i_fill_ones || (i_region == REGION_SRAM && !i_write_dropped)), "flag outside its region")

endmodule

bind bus_region_decode_waitstates brdw_checker u_brdw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_region        (o_res.region),
    .i_local_offset  (o_res.local_offset),
    .i_wait_cycles   (o_res.wait_cycles),
    .i_rtc_window    (o_res.rtc_window),
    .i_write_dropped (o_res.write_dropped),
    .i_fill_ones     (o_res.fill_ones)
);

/* tb/bus_region_decode_waitstates_tb.sv */
// ---------------------------------------------------------------------------
// Bus region decoder testbench
// Feeds bus accesses through the valid/ready access channel under several
// register settings, predicts each decode (region, offset, cycle cost, flags)
// and compares every result beat field by field, in order, with random
// idling on both channels.
// ---------------------------------------------------------------------------
module bus_region_decode_waitstates_tb;
    import brdw_pkg::*;

    // Width code three decodes as a word access.
    localparam logic [1:0] WIDTH_WIDE = 2'd3;

    localparam logic [1:0] BACKUP_EEPROM_SMALL = 2'd2;
    localparam logic [1:0] BACKUP_EEPROM_LARGE = 2'd3;

    // Halfword accesses at or above this address reach the EEPROM.
    localparam logic [31:0] EEPROM_FLOOR = 32'h0DFF_FF00;

    // VRAM offsets at or above this point fold back by clearing bit 15.
    localparam logic [16:0] VRAM_FOLD_START = 17'h1_8000;

    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 244;

    typedef struct packed {
        logic        cmd;
        logic [31:0] address;
        logic [1:0]  access_width;
        logic        sequential;
    } t_access;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    brdw_access_if acc_if ();
    brdw_result_if res_if ();

    bus_region_decode_waitstates dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Register copies that the predictor decodes against.
    logic [14:0] wait_ctl;
    logic [24:0] rom_mask;
    logic [1:0]  backup;
    logic        rtc_fitted;

    t_access     access_q[$];   // accesses waiting to be driven
    t_result     decode_q[$];   // predicted decodes of accepted accesses

    int unsigned mismatches;
    int unsigned accepted;
    int unsigned checked;
    int unsigned settings_used;
    int unsigned region_hits[11];

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Nonsequential wait-state table, indexed by a two-bit N field.
    function automatic t_wait n_cycles(input logic [1:0] field);
        case (field)
            2'd0:    return 5'd4;
            2'd1:    return 5'd3;
            2'd2:    return 5'd2;
            default: return 5'd8;
        endcase
    endfunction

    function automatic t_result decode_access(input t_access a);
        t_result     r;
        logic        is_word;
        logic        is_half;
        logic        is_write;
        logic [7:0]  page;
        logic [31:0] al;
        logic [1:0]  nfield;
        logic        sfield;
        t_wait       n_wait;
        t_wait       s_wait;
        logic [16:0] vram_off;
        r = '0;
        r.wait_cycles = 5'd1;
        is_word  = a.access_width[1];   // word and the wide code
        is_half  = (a.access_width == WIDTH_HALF);
        is_write = (a.cmd == CMD_WRITE);
        page     = a.address[31:24];
        al       = a.address;
        if (is_word) begin
            al[1:0] = 2'b00;
        end else if (is_half) begin
            al[0] = 1'b0;
        end

        if (page <= PAGE_INT_LAST) begin
            // Internal pages: fixed waits, bios and io keep the full offset.
            r.local_offset = al[27:0];
            case (page[2:0])
                3'd0: begin
                    r.region = REGION_BIOS;
                    r.write_dropped = is_write;
                end
                3'd1: begin
                    r.region = REGION_UNUSED;
                    r.local_offset = '0;
                    r.write_dropped = is_write;
                end
                3'd2: begin
                    r.region = REGION_EWRAM;
                    r.local_offset = {10'd0, al[17:0]};
                    r.wait_cycles = is_word ? 5'd6 : 5'd3;
                end
                3'd3: begin
                    r.region = REGION_IWRAM;
                    r.local_offset = {13'd0, al[14:0]};
                end
                3'd4: r.region = REGION_IO;
                3'd5: begin
                    r.region = REGION_PALETTE;
                    r.local_offset = {18'd0, al[9:0]};
                    r.wait_cycles = is_word ? 5'd2 : 5'd1;
                end
                3'd6: begin
                    r.region = REGION_VRAM;
                    vram_off = al[16:0];
                    if (vram_off >= VRAM_FOLD_START) begin
                        vram_off[15] = 1'b0;
                    end
                    r.local_offset = {11'd0, vram_off};
                    r.wait_cycles = is_word ? 5'd2 : 5'd1;
                end
                default: begin
                    r.region = REGION_OAM;
                    r.local_offset = {18'd0, al[9:0]};
                end
            endcase
        end else if (page <= PAGE_ROM_LAST) begin
            // Pick the waitstate fields: pages pair up as WS0, WS1, WS2.
            case (page[2:1])
                2'd0: begin
                    nfield = wait_ctl[3:2];
                    sfield = wait_ctl[4];
                    s_wait = 5'd2;
                end
                2'd1: begin
                    nfield = wait_ctl[6:5];
                    sfield = wait_ctl[7];
                    s_wait = 5'd4;
                end
                default: begin
                    nfield = wait_ctl[9:8];
                    sfield = wait_ctl[10];
                    s_wait = 5'd8;
                end
            endcase
            if (sfield) begin
                s_wait = 5'd1;
            end
            n_wait = n_cycles(nfield);
            if (!is_word) begin
                r.wait_cycles = 5'd1 + (a.sequential ? s_wait : n_wait);
            end else if (a.sequential) begin
                r.wait_cycles = 5'd2 * (5'd1 + s_wait);
            end else begin
                r.wait_cycles = 5'd2 + n_wait + s_wait;
            end

            if (page == PAGE_EEPROM && is_half && backup >= BACKUP_EEPROM_SMALL
                    && a.address >= EEPROM_FLOOR) begin
                r.region = REGION_EEPROM;
                r.local_offset = al[27:0];
            end else begin
                r.region = REGION_ROM;
                r.local_offset = {3'd0, al[24:0] & rom_mask};
                r.rtc_window = (r.local_offset >= 28'(RTC_FIRST))
                            && (r.local_offset <= 28'(RTC_LAST));
                r.write_dropped = is_write && !(r.rtc_window && rtc_fitted
                                                && a.access_width != WIDTH_BYTE);
            end
        end else if (page <= PAGE_SRAM_LAST) begin
            // SRAM pages are never aligned and always take the SRAM timing.
            r.region = REGION_SRAM;
            r.local_offset = a.address[27:0] & SRAM_OFFSET_MASK;
            r.wait_cycles = 5'd1 + n_cycles(wait_ctl[1:0]);
            if (backup != BACKUP_SRAM) begin
                r.write_dropped = is_write;
                r.fill_ones = !is_write;
            end
        end else begin
            r.region = REGION_UNUSED;
            r.write_dropped = is_write;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("MISMATCH beat %0d %s: got 0x%0h, expected 0x%0h",
                 checked, what, got, want);
    endtask

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_access(input logic cmd, input logic [31:0] address,
                                input logic [1:0] width, input logic seq);
        t_access a;
        a.cmd = cmd;
        a.address = address;
        a.access_width = width;
        a.sequential = seq;
        access_q.push_back(a);
    endtask

    // Sample at the falling edge so the drivers' updates have settled.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (access_q.size() != 0 || acc_if.valid || decode_q.size() != 0);
    endtask

    // Write all four registers back to back; only call while drained.
    task automatic apply_settings(input logic [14:0] wc, input logic [24:0] mask,
                                  input logic [1:0] kind, input logic rtc);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WAIT_CONTROL;
        i_cfg_data  <= CFG_DATA_W'(wc);
        @(posedge i_clk);
        i_cfg_index <= CFG_ROM_MIRROR;
        i_cfg_data  <= mask;
        @(posedge i_clk);
        i_cfg_index <= CFG_BACKUP_KIND;
        i_cfg_data  <= CFG_DATA_W'(kind);
        @(posedge i_clk);
        i_cfg_index <= CFG_RTC_PRESENT;
        i_cfg_data  <= CFG_DATA_W'(rtc);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        wait_ctl   = wc;
        rom_mask   = mask;
        backup     = kind;
        rtc_fitted = rtc;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Access driver: one beat per accepted access, random gaps between
    // ------------------------------------------------------------------
    t_access     driven;
    int unsigned send_gap;
    int unsigned send_calm;

    always @(posedge i_clk) begin : access_driver
        t_access next_access;
        if (!i_rst_n) begin
            acc_if.valid        <= 1'b0;
            acc_if.cmd          <= CMD_READ;
            acc_if.address      <= '0;
            acc_if.access_width <= WIDTH_BYTE;
            acc_if.sequential   <= 1'b0;
            send_gap  = 0;
            send_calm = 0;
        end else begin
            // Predict at the beat, with the settings in force right now.
            if (acc_if.valid && acc_if.ready) begin
                decode_q.push_back(decode_access(driven));
                accepted++;
                if (send_calm > 0) begin
                    send_calm--;
                    send_gap = 0;
                end else if ($urandom_range(0, 49) == 0) begin
                    send_calm = $urandom_range(30, 120);
                    send_gap  = 0;
                end else begin
                    send_gap = idle_len();
                end
            end
            // Advance only when the slot is free; hold a stalled beat as is.
            if (!acc_if.valid || acc_if.ready) begin
                if (send_gap > 0) begin
                    acc_if.valid <= 1'b0;
                    send_gap--;
                end else if (access_q.size() != 0) begin
                    next_access = access_q.pop_front();
                    driven = next_access;
                    acc_if.valid        <= 1'b1;
                    acc_if.cmd          <= next_access.cmd;
                    acc_if.address      <= next_access.address;
                    acc_if.access_width <= next_access.access_width;
                    acc_if.sequential   <= next_access.sequential;
                end else begin
                    acc_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random backpressure, in-order field compare
    // ------------------------------------------------------------------
    int unsigned hold_left;
    int unsigned take_calm;

    always @(posedge i_clk) begin : result_monitor
        t_result     want;
        int unsigned stall;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_left = 0;
            take_calm = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                checked++;
                if (res_if.region <= REGION_UNUSED) begin
                    region_hits[res_if.region]++;
                end
                if (decode_q.size() == 0) begin
                    report_mismatch("beat with no access pending", 32'(res_if.region), '0);
                end else begin
                    want = decode_q.pop_front();
                    if (res_if.region !== want.region)
                        report_mismatch("region", 32'(res_if.region), 32'(want.region));
                    if (res_if.local_offset !== want.local_offset)
                        report_mismatch("local_offset", 32'(res_if.local_offset),
                                        32'(want.local_offset));
                    if (res_if.wait_cycles !== want.wait_cycles)
                        report_mismatch("wait_cycles", 32'(res_if.wait_cycles),
                                        32'(want.wait_cycles));
                    if (res_if.rtc_window !== want.rtc_window)
                        report_mismatch("rtc_window", 32'(res_if.rtc_window),
                                        32'(want.rtc_window));
                    if (res_if.write_dropped !== want.write_dropped)
                        report_mismatch("write_dropped", 32'(res_if.write_dropped),
                                        32'(want.write_dropped));
                    if (res_if.fill_ones !== want.fill_ones)
                        report_mismatch("fill_ones", 32'(res_if.fill_ones),
                                        32'(want.fill_ones));
                end
            end
            // Drop ready for a stall, or keep it up through a calm stretch.
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (take_calm > 0) begin
                res_if.ready <= 1'b1;
                take_calm--;
            end else if ($urandom_range(0, 49) == 0) begin
                res_if.ready <= 1'b1;
                take_calm = $urandom_range(30, 120);
            end else begin
                stall = idle_len();
                if (stall == 0) begin
                    res_if.ready <= 1'b1;
                end else begin
                    res_if.ready <= 1'b0;
                    hold_left = stall - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned kind;
        int unsigned wsel;
        logic [31:0] addr;
        logic [1:0]  width;
        logic [24:0] mask;

        // Known configuration values from time zero.
        i_cfg_we            = 1'b0;
        i_cfg_index         = CFG_WAIT_CONTROL;
        i_cfg_data          = '0;
        wait_ctl            = WAIT_CONTROL_RESET;
        rom_mask            = ROM_MIRROR_RESET;
        backup              = BACKUP_NONE;
        rtc_fitted          = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: every internal page, width extremes, unused pages.
        queue_access(CMD_READ,  32'h0000_0003, WIDTH_WORD, 1'b0);
        queue_access(CMD_WRITE, 32'h0000_1234, WIDTH_BYTE, 1'b0);
        queue_access(CMD_WRITE, 32'h01AB_CDEF, WIDTH_HALF, 1'b1);
        queue_access(CMD_READ,  32'h0203_FFFF, WIDTH_WORD, 1'b1);
        queue_access(CMD_READ,  32'h03FF_FFFF, WIDTH_HALF, 1'b0);
        queue_access(CMD_WRITE, 32'h0400_0301, WIDTH_BYTE, 1'b0);
        queue_access(CMD_READ,  32'h05FF_FFFF, WIDTH_WORD, 1'b0);
        queue_access(CMD_READ,  32'h0601_FFFF, WIDTH_HALF, 1'b0);  // folds back
        queue_access(CMD_READ,  32'h0601_7FFF, WIDTH_BYTE, 1'b0);  // just below fold
        queue_access(CMD_READ,  32'h0700_0007, WIDTH_WIDE, 1'b1);
        queue_access(CMD_READ,  32'h0800_0000, WIDTH_WORD, 1'b0);
        queue_access(CMD_READ,  32'h0DFF_FFFF, WIDTH_HALF, 1'b1);  // no EEPROM fitted
        queue_access(CMD_READ,  32'h0E00_FFFF, WIDTH_BYTE, 1'b0);  // reads all ones
        queue_access(CMD_WRITE, 32'h0FFF_FFFF, WIDTH_WORD, 1'b1);
        queue_access(CMD_WRITE, 32'hFFFF_FFFF, WIDTH_WORD, 1'b0);
        queue_access(CMD_READ,  32'h1000_0000, WIDTH_BYTE, 1'b0);
        wait_drained();

        // Slowest nonsequential waits with the S bits set, large EEPROM and the clock port fitted.
        apply_settings(15'h7FFF, 25'h1FF_FFFF, BACKUP_EEPROM_LARGE, 1'b1);
        queue_access(CMD_WRITE, 32'h0DFF_FF00, WIDTH_HALF, 1'b0);  // EEPROM floor
        queue_access(CMD_READ,  32'h0DFF_FEFF, WIDTH_HALF, 1'b0);  // just below
        queue_access(CMD_READ,  32'h0DFF_FF01, WIDTH_HALF, 1'b1);
        queue_access(CMD_READ,  32'h0DFF_FF10, WIDTH_BYTE, 1'b0);  // bytes stay ROM
        queue_access(CMD_READ,  32'h0DFF_FF10, WIDTH_WORD, 1'b1);  // words stay ROM
        queue_access(CMD_WRITE, 32'h0800_00C5, WIDTH_HALF, 1'b0);  // clock port write
        queue_access(CMD_WRITE, 32'h0800_00C9, WIDTH_BYTE, 1'b0);  // byte always dropped
        queue_access(CMD_WRITE, 32'h0A00_00CA, WIDTH_WORD, 1'b0);  // aligns into window
        queue_access(CMD_WRITE, 32'h0E00_0000, WIDTH_BYTE, 1'b0);  // SRAM not fitted
        wait_drained();

        // Random phases: the first two pin the register extremes.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: apply_settings(15'h0000, 25'h000_0000, BACKUP_SRAM, 1'b0);
                1: apply_settings(15'h7FFF, 25'h1FF_FFFF, BACKUP_EEPROM_SMALL, 1'b1);
                default: begin
                    case ($urandom_range(0, 2))
                        0:       mask = 25'h1FF_FFFF;
                        1:       mask = (25'h1 << $urandom_range(8, 24)) - 25'h1;
                        default: mask = 25'($urandom);
                    endcase
                    apply_settings(15'($urandom), mask, 2'($urandom), 1'($urandom));
                end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                kind = $urandom_range(0, 15);
                addr = $urandom;
                case (kind) inside
                    [0:7]: addr[31:24] = 8'($urandom_range(0, 15));
                    8, 9: begin
                        // Aim at the clock port window, with or without high bits.
                        addr[31:24] = 8'($urandom_range(8, 13));
                        if (kind == 8) begin
                            addr[23:8] = '0;
                        end
                        addr[7:0] = 8'($urandom_range(8'hC0, 8'hCF));
                    end
                    10: addr = 32'h0DFF_FE00 + $urandom_range(0, 511);
                    11: begin
                        addr[31:24] = 8'h06;
                        addr[16:15] = 2'b11;
                    end
                    12: addr[31:24] = 8'($urandom_range(14, 15));
                    13: begin
                        if (addr[31:28] == 4'h0) begin
                            addr[31:28] = 4'($urandom_range(1, 15));
                        end
                    end
                    14: addr[31:24] = 8'h01;
                    default: ;
                endcase
                wsel = $urandom_range(0, 9);
                if (wsel < 3) begin
                    width = WIDTH_BYTE;
                end else if (wsel < 6) begin
                    width = WIDTH_HALF;
                end else if (wsel < 9) begin
                    width = WIDTH_WORD;
                end else begin
                    width = WIDTH_WIDE;
                end
                queue_access(1'($urandom), addr, width, 1'($urandom));
            end
            wait_drained();
        end

        // Let the two-stage pipeline settle before the verdict.
        repeat (8) @(posedge i_clk);
        $display("Decoded %0d accesses under %0d register settings, %0d result beats checked",
                 accepted, settings_used + 1, checked);
        $display("Beats per region bios..unused: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 region_hits[0], region_hits[1], region_hits[2], region_hits[3],
                 region_hits[4], region_hits[5], region_hits[6], region_hits[7],
                 region_hits[8], region_hits[9], region_hits[10]);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #12_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/brdw_pkg.sv
rtl/core/brdw_access_if.sv
rtl/core/brdw_result_if.sv
rtl/core/bus_region_decode_waitstates.sv
rtl/core/brdw_checker.sv
tb/bus_region_decode_waitstates_tb.sv
